// ----- sv/tpc_pkg.sv -----
// Shared constants for the triangle pixel classifier.
`timescale 1ns / 1ps

package tpc_pkg;

   localparam int VERT_W      = 17;
   localparam int VDIFF_W     = 18;
   localparam int AREA_PROD_W = 36;
   localparam int AREA_W      = 37;
   localparam int ABS_LIMIT_W = 31;
   localparam int BW_THR_W    = 5;

   localparam logic [1:0] CLASS_OUTSIDE = 2'd0;
   localparam logic [1:0] CLASS_FILL    = 2'd1;
   localparam logic [1:0] CLASS_EDGE    = 2'd2;

   localparam logic [1:0] SKIP_AB = 2'd1;
   localparam logic [1:0] SKIP_BC = 2'd2;
   localparam logic [1:0] SKIP_CA = 2'd3;

   localparam logic [1:0] LANE_SKIP_CODE [3] = '{SKIP_AB, SKIP_BC, SKIP_CA};

endpackage

// ----- sv/triangle_pixel_classifier_core.sv -----
// Pipelined edge-function classifier of one pixel against one triangle.
// Six register stages carry each beat, s1 to s5 and the output register, with the
// valid bits moving alongside them; the result strobe rsp_valid is registered.
// Throughput: one beat per cycle; busy is always low and the pipeline never stalls.
// Reset clears only the stage valid bits, so no result appears until a beat is accepted.
`timescale 1ns / 1ps

module triangle_pixel_classifier_core
   import tpc_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [11:0]        req_pixel_x,
   input  logic [11:0]        req_pixel_y,
   input  logic signed [15:0] req_vertex_a_x,
   input  logic signed [15:0] req_vertex_a_y,
   input  logic signed [15:0] req_vertex_b_x,
   input  logic signed [15:0] req_vertex_b_y,
   input  logic signed [15:0] req_vertex_c_x,
   input  logic signed [15:0] req_vertex_c_y,
   input  logic [3:0]         req_band_width,
   input  logic [1:0]         req_skip_edge,
   output logic               rsp_valid,
   output logic [1:0]         rsp_pixel_class
);

   localparam int PW      = 13 + COORD_FRAC_BITS;
   localparam int CW      = ((PW > VERT_W) ? PW : VERT_W) + 2;
   localparam int PROD_W  = 2 * CW;
   localparam int EDGE_W  = PROD_W + 1;
   localparam int TW      = BW_THR_W + COORD_FRAC_BITS;
   localparam int TDW     = TW + VDIFF_W + 1;
   localparam int SQ_W    = 2 * TDW;
   localparam int AE2_W   = 2 * ABS_LIMIT_W;
   localparam int CMP_W   = (AE2_W > SQ_W) ? AE2_W : SQ_W;

   logic accept;
   logic [4:0] valid_ff;
   logic rsp_valid_ff;
   logic [1:0] rsp_pixel_class_ff;
   logic [1:0] rsp_pixel_class_in;

   logic signed [CW-1:0] pixel_x_fix;
   logic signed [CW-1:0] pixel_y_fix;
   logic signed [CW-1:0] vert_x_wide [3];
   logic signed [CW-1:0] vert_y_wide [3];
   logic signed [VERT_W-1:0] vert_x [3];
   logic signed [VERT_W-1:0] vert_y [3];

   logic signed [VDIFF_W-1:0] s1_cax_ff, s1_cby_ff, s1_cay_ff, s1_cbx_ff;
   logic [TW-1:0] s1_thr_ff;
   logic s1_bwnz_ff;
   logic [1:0] s1_skip_ff;

   logic signed [AREA_PROD_W-1:0] s2_am1_ff, s2_am2_ff;
   logic s2_bwnz_ff;
   logic [1:0] s2_skip_ff;

   logic signed [AREA_W-1:0] s3_area_ff;
   logic s3_bwnz_ff;
   logic [1:0] s3_skip_ff;

   logic s4_inside_ff;
   logic s4_inside_in;
   logic s5_inside_ff;

   wire [2:0] lane_neg;
   wire [2:0] lane_zero;
   wire [2:0] lane_near;

   logic area_pos;
   logic area_neg;

   assign busy = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      pixel_x_fix = signed'(CW'({req_pixel_x, 1'b1}) << COORD_FRAC_BITS);
      pixel_y_fix = signed'(CW'({req_pixel_y, 1'b1}) << COORD_FRAC_BITS);
      vert_x[0] = {req_vertex_a_x, 1'b0};
      vert_y[0] = {req_vertex_a_y, 1'b0};
      vert_x[1] = {req_vertex_b_x, 1'b0};
      vert_y[1] = {req_vertex_b_y, 1'b0};
      vert_x[2] = {req_vertex_c_x, 1'b0};
      vert_y[2] = {req_vertex_c_y, 1'b0};
   end

   for (genvar vi = 0; vi < 3; vi++) begin : g_vert
      assign vert_x_wide[vi] = {{(CW - VERT_W){vert_x[vi][VERT_W-1]}}, vert_x[vi]};
      assign vert_y_wide[vi] = {{(CW - VERT_W){vert_y[vi][VERT_W-1]}}, vert_y[vi]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[3:0], accept};
         rsp_valid_ff <= valid_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      s1_cax_ff <= {vert_x[2][VERT_W-1], vert_x[2]} - {vert_x[0][VERT_W-1], vert_x[0]};
      s1_cby_ff <= {vert_y[2][VERT_W-1], vert_y[2]} - {vert_y[1][VERT_W-1], vert_y[1]};
      s1_cay_ff <= {vert_y[2][VERT_W-1], vert_y[2]} - {vert_y[0][VERT_W-1], vert_y[0]};
      s1_cbx_ff <= {vert_x[2][VERT_W-1], vert_x[2]} - {vert_x[1][VERT_W-1], vert_x[1]};
      s1_thr_ff <= TW'({req_band_width, 1'b0} - BW_THR_W'(1)) << COORD_FRAC_BITS;
      s1_bwnz_ff <= |req_band_width;
      s1_skip_ff <= req_skip_edge;

      s2_am1_ff <= s1_cax_ff * s1_cby_ff;
      s2_am2_ff <= s1_cay_ff * s1_cbx_ff;
      s2_bwnz_ff <= s1_bwnz_ff;
      s2_skip_ff <= s1_skip_ff;

      s3_area_ff <= s2_am1_ff - s2_am2_ff;
      s3_bwnz_ff <= s2_bwnz_ff;
      s3_skip_ff <= s2_skip_ff;

      s4_inside_ff <= s4_inside_in;
      s5_inside_ff <= s4_inside_ff;

      rsp_pixel_class_ff <= rsp_pixel_class_in;
   end

   for (genvar lane = 0; lane < 3; lane++) begin : g_lane
      localparam int NEXT = (lane == 2) ? 0 : lane + 1;

      logic signed [CW-1:0] s1_pux_ff, s1_pvy_ff, s1_puy_ff, s1_pvx_ff;
      logic signed [VDIFF_W-1:0] s1_evx_ff, s1_evy_ff;
      logic signed [PROD_W-1:0] s2_m1_ff, s2_m2_ff;
      logic signed [TDW-1:0] s2_tdx_ff, s2_tdy_ff;
      logic signed [EDGE_W-1:0] s3_e_ff;
      logic signed [SQ_W-1:0] s3_sqx_ff, s3_sqy_ff;
      logic [EDGE_W-1:0] e_mag;
      logic [ABS_LIMIT_W-1:0] s4_ae_ff;
      logic s4_big_ff;
      logic [SQ_W-1:0] s4_rhs_ff;
      logic s4_en_ff;
      logic [AE2_W-1:0] s5_ae2_ff;
      logic s5_big_ff;
      logic [SQ_W-1:0] s5_rhs_ff;
      logic s5_en_ff;

      assign e_mag = s3_e_ff[EDGE_W-1] ? unsigned'(-s3_e_ff) : unsigned'(s3_e_ff);
      assign lane_neg[lane] = s3_e_ff[EDGE_W-1];
      assign lane_zero[lane] = (s3_e_ff == '0);
      assign lane_near[lane] = s5_en_ff && !s5_big_ff
                               && (CMP_W'(s5_ae2_ff) <= CMP_W'(s5_rhs_ff));

      always_ff @(posedge clock) begin
         s1_pux_ff <= pixel_x_fix - vert_x_wide[lane];
         s1_pvy_ff <= pixel_y_fix - vert_y_wide[NEXT];
         s1_puy_ff <= pixel_y_fix - vert_y_wide[lane];
         s1_pvx_ff <= pixel_x_fix - vert_x_wide[NEXT];
         s1_evx_ff <= {vert_x[lane][VERT_W-1], vert_x[lane]}
                      - {vert_x[NEXT][VERT_W-1], vert_x[NEXT]};
         s1_evy_ff <= {vert_y[lane][VERT_W-1], vert_y[lane]}
                      - {vert_y[NEXT][VERT_W-1], vert_y[NEXT]};

         s2_m1_ff <= s1_pux_ff * s1_pvy_ff;
         s2_m2_ff <= s1_puy_ff * s1_pvx_ff;
         s2_tdx_ff <= signed'({1'b0, s1_thr_ff}) * s1_evx_ff;
         s2_tdy_ff <= signed'({1'b0, s1_thr_ff}) * s1_evy_ff;

         s3_e_ff <= s2_m1_ff - s2_m2_ff;
         s3_sqx_ff <= s2_tdx_ff * s2_tdx_ff;
         s3_sqy_ff <= s2_tdy_ff * s2_tdy_ff;

         s4_ae_ff <= e_mag[ABS_LIMIT_W-1:0];
         s4_big_ff <= |e_mag[EDGE_W-1:ABS_LIMIT_W];
         s4_rhs_ff <= unsigned'(s3_sqx_ff) + unsigned'(s3_sqy_ff);
         s4_en_ff <= s3_bwnz_ff && (s3_skip_ff != LANE_SKIP_CODE[lane]);

         s5_ae2_ff <= s4_ae_ff * s4_ae_ff;
         s5_big_ff <= s4_big_ff;
         s5_rhs_ff <= s4_rhs_ff;
         s5_en_ff <= s4_en_ff;
      end
   end

   always_comb begin
      area_neg = s3_area_ff[AREA_W-1];
      area_pos = !area_neg && (s3_area_ff != '0);
      if (area_pos) begin
         s4_inside_in = (lane_neg == 3'b000);
      end else if (area_neg) begin
         s4_inside_in = ((lane_neg | lane_zero) == 3'b111);
      end else begin
         s4_inside_in = 1'b0;
      end
   end

   always_comb begin
      if (!s5_inside_ff) begin
         rsp_pixel_class_in = CLASS_OUTSIDE;
      end else if (|lane_near) begin
         rsp_pixel_class_in = CLASS_EDGE;
      end else begin
         rsp_pixel_class_in = CLASS_FILL;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_class = rsp_pixel_class_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("accepted beat did not produce a result six edges later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 6))
      else $error("result strobe without an accepted beat");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && (s3_area_ff == '0)) |=> !s4_inside_ff)
      else $error("zero-area triangle classified as inside");

   a_outside_class: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !s4_inside_ff) |-> ##2 (rsp_pixel_class == CLASS_OUTSIDE))
      else $error("outside pixel delivered with a nonzero class");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the triangle pixel classifier core, directed and random beats.
`timescale 1ns / 1ps

module tb;
   import tpc_pkg::*;

   localparam int FRAC_BITS = 4;
   localparam int RUN_LIMIT = 200000;
   localparam int RANDOM_BEATS = 500;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_GAP = 7;
   localparam logic [1:0] SKIP_NONE = 2'd0;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [15:0] vertex_a_x;
      logic [15:0] vertex_a_y;
      logic [15:0] vertex_b_x;
      logic [15:0] vertex_b_y;
      logic [15:0] vertex_c_x;
      logic [15:0] vertex_c_y;
      logic [3:0]  band_width;
      logic [1:0]  skip_edge;
   } pixel_beat_t;

   typedef struct packed {
      pixel_beat_t beat;
      logic        typed;
      logic [1:0]  pixel_class;
   } directed_row_t;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [11:0]        req_pixel_x = '0;
   logic [11:0]        req_pixel_y = '0;
   logic signed [15:0] req_vertex_a_x = '0;
   logic signed [15:0] req_vertex_a_y = '0;
   logic signed [15:0] req_vertex_b_x = '0;
   logic signed [15:0] req_vertex_b_y = '0;
   logic signed [15:0] req_vertex_c_x = '0;
   logic signed [15:0] req_vertex_c_y = '0;
   logic [3:0]         req_band_width = '0;
   logic [1:0]         req_skip_edge = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_pixel_class;

   logic [1:0]    expected_classes [$];
   directed_row_t directed_rows [$];
   logic [1:0]    oldest_class;
   int            error_count = 0;
   int            cycle_count = 0;

   triangle_pixel_classifier_core #(
      .COORD_FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_vertex_a_x(req_vertex_a_x),
      .req_vertex_a_y(req_vertex_a_y),
      .req_vertex_b_x(req_vertex_b_x),
      .req_vertex_b_y(req_vertex_b_y),
      .req_vertex_c_x(req_vertex_c_x),
      .req_vertex_c_y(req_vertex_c_y),
      .req_band_width(req_band_width),
      .req_skip_edge(req_skip_edge),
      .rsp_valid(rsp_valid),
      .rsp_pixel_class(rsp_pixel_class)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint edge_value(input longint px, input longint py,
                                         input longint ux, input longint uy,
                                         input longint vx, input longint vy);
      return (px - ux) * (py - vy) - (py - uy) * (px - vx);
   endfunction

   function automatic bit within_band(input longint e, input longint ux, input longint uy,
                                      input longint vx, input longint vy,
                                      input longint thr);
      longint mag;
      longint dx;
      longint dy;
      longint len2;
      mag = (e < 0) ? -e : e;
      dx = ux - vx;
      dy = uy - vy;
      len2 = dx * dx + dy * dy;
      if (mag >= 64'sd2147483648) return 1'b0;
      return mag * mag <= thr * thr * len2;
   endfunction

   function automatic logic [1:0] classify_pixel(input pixel_beat_t b);
      longint px;
      longint py;
      longint ax;
      longint ay;
      longint bx;
      longint by;
      longint cx;
      longint cy;
      longint area;
      longint e_ab;
      longint e_bc;
      longint e_ca;
      longint thr;
      bit pix_in;
      logic [1:0] cls;
      px = (2 * longint'(b.pixel_x) + 1) <<< FRAC_BITS;
      py = (2 * longint'(b.pixel_y) + 1) <<< FRAC_BITS;
      ax = 2 * longint'($signed(b.vertex_a_x));
      ay = 2 * longint'($signed(b.vertex_a_y));
      bx = 2 * longint'($signed(b.vertex_b_x));
      by = 2 * longint'($signed(b.vertex_b_y));
      cx = 2 * longint'($signed(b.vertex_c_x));
      cy = 2 * longint'($signed(b.vertex_c_y));
      area = edge_value(cx, cy, ax, ay, bx, by);
      e_ab = edge_value(px, py, ax, ay, bx, by);
      e_bc = edge_value(px, py, bx, by, cx, cy);
      e_ca = edge_value(px, py, cx, cy, ax, ay);
      if (area > 0) pix_in = (e_ab >= 0) && (e_bc >= 0) && (e_ca >= 0);
      else if (area < 0) pix_in = (e_ab <= 0) && (e_bc <= 0) && (e_ca <= 0);
      else pix_in = 1'b0;
      cls = CLASS_OUTSIDE;
      if (pix_in) begin
         cls = CLASS_FILL;
         if (b.band_width != 0) begin
            thr = (2 * longint'(b.band_width) - 1) <<< FRAC_BITS;
            if ((b.skip_edge != SKIP_AB && within_band(e_ab, ax, ay, bx, by, thr)) ||
                (b.skip_edge != SKIP_BC && within_band(e_bc, bx, by, cx, cy, thr)) ||
                (b.skip_edge != SKIP_CA && within_band(e_ca, cx, cy, ax, ay, thr)))
               cls = CLASS_EDGE;
         end
      end
      return cls;
   endfunction

   function automatic logic [15:0] clamp_coord(input longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic logic [15:0] jitter_coord(input longint centre, input longint span);
      return clamp_coord(centre + longint'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Most triangles are placed around the pixel so that all three classes show up.
   function automatic pixel_beat_t random_beat();
      pixel_beat_t b;
      longint centre_x;
      longint centre_y;
      longint span;
      longint dx;
      longint dy;
      int mode;
      mode = $urandom_range(0, 9);
      b.pixel_x = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2047));
      b.pixel_y = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2047));
      b.band_width = 4'($urandom);
      b.skip_edge = 2'($urandom);
      centre_x = (2 * longint'(b.pixel_x) + 1) <<< (FRAC_BITS - 1);
      centre_y = (2 * longint'(b.pixel_y) + 1) <<< (FRAC_BITS - 1);
      span = longint'(16) <<< $urandom_range(0, 10);
      b.vertex_a_x = jitter_coord(centre_x, span);
      b.vertex_a_y = jitter_coord(centre_y, span);
      b.vertex_b_x = jitter_coord(centre_x, span);
      b.vertex_b_y = jitter_coord(centre_y, span);
      b.vertex_c_x = jitter_coord(centre_x, span);
      b.vertex_c_y = jitter_coord(centre_y, span);
      if (mode == 0) begin
         b.vertex_a_x = 16'($urandom);
         b.vertex_a_y = 16'($urandom);
         b.vertex_b_x = 16'($urandom);
         b.vertex_b_y = 16'($urandom);
         b.vertex_c_x = 16'($urandom);
         b.vertex_c_y = 16'($urandom);
      end else if (mode == 1) begin
         dx = ($urandom_range(0, 1) == 0) ? 0 : longint'($urandom_range(0, 64)) - 32;
         dy = ($urandom_range(0, 1) == 0) ? 0 : longint'($urandom_range(0, 64)) - 32;
         b.vertex_b_x = clamp_coord(longint'($signed(b.vertex_a_x)) + dx);
         b.vertex_b_y = clamp_coord(longint'($signed(b.vertex_a_y)) + dy);
         b.vertex_c_x = clamp_coord(longint'($signed(b.vertex_a_x)) + 2 * dx);
         b.vertex_c_y = clamp_coord(longint'($signed(b.vertex_a_y)) + 2 * dy);
      end
      return b;
   endfunction

   task automatic add_row(input int px, input int py, input int ax, input int ay,
                          input int bx, input int by, input int cx, input int cy,
                          input int bw, input logic [1:0] skip, input logic typed,
                          input logic [1:0] cls);
      directed_row_t r;
      r.beat.pixel_x = 12'(px);
      r.beat.pixel_y = 12'(py);
      r.beat.vertex_a_x = 16'(ax);
      r.beat.vertex_a_y = 16'(ay);
      r.beat.vertex_b_x = 16'(bx);
      r.beat.vertex_b_y = 16'(by);
      r.beat.vertex_c_x = 16'(cx);
      r.beat.vertex_c_y = 16'(cy);
      r.beat.band_width = 4'(bw);
      r.beat.skip_edge = skip;
      r.typed = typed;
      r.pixel_class = cls;
      directed_rows.push_back(r);
   endtask

   task automatic send_beat(input pixel_beat_t b, input logic [1:0] cls, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_pixel_x <= b.pixel_x;
      req_pixel_y <= b.pixel_y;
      req_vertex_a_x <= b.vertex_a_x;
      req_vertex_a_y <= b.vertex_a_y;
      req_vertex_b_x <= b.vertex_b_x;
      req_vertex_b_y <= b.vertex_b_y;
      req_vertex_c_x <= b.vertex_c_x;
      req_vertex_c_y <= b.vertex_c_y;
      req_band_width <= b.band_width;
      req_skip_edge <= b.skip_edge;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_classes.push_back(cls);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_classes.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_classes.size() == 0) begin
            $error("pixel_class: expected none, got %0d", rsp_pixel_class);
            error_count++;
         end else begin
            oldest_class = expected_classes.pop_front();
            if (rsp_pixel_class !== oldest_class) begin
               $error("pixel_class: expected %0d, got %0d", oldest_class, rsp_pixel_class);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      pixel_beat_t b;
      directed_row_t row;
      int gap;
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, SKIP_NONE, 1'b1, CLASS_OUTSIDE);
      add_row(5, 5, 0, 0, 160, 160, 320, 320, 3, SKIP_NONE, 1'b1, CLASS_OUTSIDE);
      add_row(4095, 4095, 0, 0, 32767, 0, 0, 32767, 15, SKIP_NONE, 1'b1, CLASS_OUTSIDE);
      add_row(10, 10, 0, 0, 32767, 0, 0, 32767, 0, SKIP_NONE, 1'b1, CLASS_FILL);
      add_row(10, 10, 0, 0, 0, 32767, 32767, 0, 0, SKIP_NONE, 1'b1, CLASS_FILL);
      add_row(0, 0, 0, 0, 32767, 0, 0, 32767, 15, SKIP_NONE, 1'b1, CLASS_EDGE);
      add_row(0, 0, 0, 0, 32767, 0, 0, 32767, 1, SKIP_NONE, 1'b1, CLASS_EDGE);
      add_row(1, 5, 0, 0, 32767, 0, 0, 32767, 1, SKIP_NONE, 1'b0, CLASS_OUTSIDE);
      add_row(0, 5, 0, 0, 32767, 0, 0, 32767, 1, SKIP_CA, 1'b0, CLASS_OUTSIDE);
      add_row(0, 5, 0, 0, 32767, 0, 0, 32767, 1, SKIP_AB, 1'b0, CLASS_OUTSIDE);
      add_row(1023, 1023, 0, 0, 32767, 0, 0, 32767, 1, SKIP_NONE, 1'b0, CLASS_OUTSIDE);
      add_row(1023, 1023, 0, 0, 32767, 0, 0, 32767, 2, SKIP_NONE, 1'b0, CLASS_OUTSIDE);
      add_row(1023, 1023, 0, 0, 32767, 0, 0, 32767, 2, SKIP_BC, 1'b0, CLASS_OUTSIDE);
      add_row(20, 20, 0, 0, 32767, 0, 0, 32767, 15, SKIP_NONE, 1'b0, CLASS_OUTSIDE);
      add_row(14, 100, 0, 0, 32767, 0, 0, 32767, 15, SKIP_NONE, 1'b0, CLASS_OUTSIDE);
      add_row(0, 0, -32768, -32768, 32767, -32768, -32768, 32767, 15, SKIP_NONE,
              1'b0, CLASS_OUTSIDE);
      add_row(4095, 0, -32768, -32768, 32767, -32768, -32768, 32767, 15, SKIP_NONE,
              1'b1, CLASS_OUTSIDE);
      add_row(0, 0, 8, 8, 168, 8, 8, 168, 0, SKIP_NONE, 1'b1, CLASS_FILL);
      add_row(3, 0, 8, 8, 168, 8, 8, 168, 0, SKIP_NONE, 1'b1, CLASS_FILL);
      add_row(3, 0, 8, 8, 168, 8, 8, 168, 15, SKIP_AB, 1'b0, CLASS_OUTSIDE);
      add_row(2730, 1365, -1, -1, -21846, 21845, 21845, -21846, 10, SKIP_BC,
              1'b0, CLASS_OUTSIDE);
      add_row(1365, 2730, 32767, -32768, -32768, -32768, 32767, 32767, 15, SKIP_CA,
              1'b0, CLASS_OUTSIDE);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.beat, row.typed ? row.pixel_class : classify_pixel(row.beat),
                   $urandom_range(0, MAX_GAP));
      end
      drain_results();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == RANDOM_BEATS / 2) drain_results();
         b = random_beat();
         gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
         send_beat(b, classify_pixel(b), gap);
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tpc_pkg.sv
sv/triangle_pixel_classifier_core.sv
sim/tb.sv
